>>> rtl/core/fbpa_pkg.sv
// Package for the fixed-block pool allocator.
// Holds pool geometry, field widths and result status codes.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  localparam int NUM_BLOCKS  = 32;
  localparam int BLOCK_BYTES = 64;

  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int COUNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int STATUS_W    = 2;

  localparam int OUT_DATA_W  = ((ADDR_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - ADDR_W - COUNT_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EMPTY       = 2'd1,
    STATUS_BAD_ADDR    = 2'd2,
    STATUS_DOUBLE_FREE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

endpackage

`default_nettype wire

>>> rtl/core/fixed_block_pool_allocator_unit.sv
// Fixed-block pool allocator with a circular free list, top level.
// Depends on fbpa_pkg for geometry, widths and status codes.
// Request path: an accepted request is held in an input register, then its result in an output register.
// Throughput: one request per cycle while the output is not stalled; ring, flags and count update on advance.
// Reset: synchronous; the ring holds index i at entry i, all blocks free, base zero.
`default_nettype none

module fixed_block_pool_allocator_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]        cfg_wdata,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]        s_tdata,  // address
  input  wire logic                               s_tuser,  // op
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [fbpa_pkg::OUT_DATA_W-1:0]         m_tdata,  // block_address, free_count, zero pad
  output logic [fbpa_pkg::STATUS_W-1:0]           m_tuser   // status
);

  localparam logic [fbpa_pkg::COUNT_W-1:0] FULL_COUNT =
    fbpa_pkg::COUNT_W'(fbpa_pkg::NUM_BLOCKS);
  localparam logic [fbpa_pkg::IDX_W-1:0] LAST_POS =
    fbpa_pkg::IDX_W'(fbpa_pkg::NUM_BLOCKS - 1);

  logic [fbpa_pkg::ADDR_W-1:0]   pool_base;
  logic                          in_valid;
  fbpa_pkg::op_t                 in_op;
  logic [fbpa_pkg::ADDR_W-1:0]   in_address;

  logic [fbpa_pkg::IDX_W-1:0]    free_ring [fbpa_pkg::NUM_BLOCKS];
  logic [fbpa_pkg::NUM_BLOCKS-1:0] used_flags;
  logic [fbpa_pkg::IDX_W-1:0]    pop_position;
  logic [fbpa_pkg::IDX_W-1:0]    push_position;
  logic [fbpa_pkg::COUNT_W-1:0]  free_blocks;

  logic [fbpa_pkg::ADDR_W-1:0]   out_address;
  fbpa_pkg::status_t             out_status;
  logic [fbpa_pkg::COUNT_W-1:0]  out_count;

  logic                          advance;
  logic [fbpa_pkg::ADDR_W-1:0]   offset;
  logic [fbpa_pkg::IDX_W-1:0]    pop_idx;
  logic [fbpa_pkg::IDX_W-1:0]    free_idx;
  logic                          bad_addr;
  logic                          do_alloc;
  logic                          do_free;
  fbpa_pkg::status_t             status_next;
  logic [fbpa_pkg::ADDR_W-1:0]   address_next;
  logic [fbpa_pkg::COUNT_W-1:0]  free_blocks_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    offset   = in_address - pool_base;
    pop_idx  = free_ring[pop_position];
    free_idx = offset[fbpa_pkg::BLOCK_SHIFT +: fbpa_pkg::IDX_W];
    bad_addr = (in_address == '0) || (in_address < pool_base) ||
               (offset[fbpa_pkg::ADDR_W-1:fbpa_pkg::BLOCK_SHIFT+fbpa_pkg::IDX_W] != '0) ||
               (offset[fbpa_pkg::BLOCK_SHIFT-1:0] != '0);
    do_alloc = 1'b0;
    do_free  = 1'b0;
    address_next     = '0;
    free_blocks_next = free_blocks;
    status_next      = fbpa_pkg::STATUS_OK;
    if (in_op == fbpa_pkg::OP_ALLOC) begin
      if (free_blocks == '0) begin
        status_next = fbpa_pkg::STATUS_EMPTY;
      end else begin
        do_alloc = 1'b1;
        address_next = pool_base +
          (fbpa_pkg::ADDR_W'(pop_idx) << fbpa_pkg::BLOCK_SHIFT);
        free_blocks_next = free_blocks - 1'b1;
      end
    end else if (bad_addr) begin
      status_next = fbpa_pkg::STATUS_BAD_ADDR;
    end else if (!used_flags[free_idx]) begin
      status_next = fbpa_pkg::STATUS_DOUBLE_FREE;
    end else begin
      do_free = 1'b1;
      free_blocks_next = free_blocks + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op      <= fbpa_pkg::op_t'(s_tuser);
      in_address <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbpa_pkg::NUM_BLOCKS; i++) begin
        free_ring[i] <= fbpa_pkg::IDX_W'(i);
      end
      used_flags    <= '0;
      pop_position  <= '0;
      push_position <= '0;
      free_blocks   <= FULL_COUNT;
    end else if (advance) begin
      free_blocks <= free_blocks_next;
      if (do_alloc) begin
        used_flags[pop_idx] <= 1'b1;
        pop_position <= (pop_position == LAST_POS) ? '0 : pop_position + 1'b1;
      end
      if (do_free) begin
        used_flags[free_idx]     <= 1'b0;
        free_ring[push_position] <= free_idx;
        push_position <= (push_position == LAST_POS) ? '0 : push_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_address <= address_next;
      out_status  <= status_next;
      out_count   <= free_blocks_next;
    end
  end

  assign m_tdata = {{fbpa_pkg::OUT_PAD_W{1'b0}}, out_count, out_address};
  assign m_tuser = out_status;

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (32'($countones(used_flags)) + 32'(free_blocks)) == 32'(fbpa_pkg::NUM_BLOCKS))
    else $error("free count disagrees with used flags");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= FULL_COUNT)
    else $error("free count exceeds pool size");

  a_address_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != fbpa_pkg::STATUS_OK) |-> (out_address == '0))
    else $error("failed request returned a block address");

  a_empty_when_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == fbpa_pkg::OP_ALLOC && free_blocks == '0) |=>
      (out_status == fbpa_pkg::STATUS_EMPTY && $stable(used_flags)))
    else $error("allocate from empty pool changed state");

endmodule

`default_nettype wire
